// File: sv/pcg_hash_range_generator_defines.svh
// Assertion macros shared by the block's modules.
`ifndef PCG_HASH_RANGE_GENERATOR_DEFINES_SVH
`define PCG_HASH_RANGE_GENERATOR_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define PCGH_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define PCGH_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/pcgh_pkg.sv
package pcgh_pkg;

    localparam int WordWidth  = 32;
    localparam int CfgIdxWidth = 8;

    typedef logic [WordWidth-1:0]   word_t;
    typedef logic [CfgIdxWidth-1:0] cfg_idx_t;

    localparam cfg_idx_t CfgIdxLow  = cfg_idx_t'(0);
    localparam cfg_idx_t CfgIdxHigh = cfg_idx_t'(1);

    localparam word_t PcgMulA = 32'd747796405;
    localparam word_t PcgAddA = 32'd2891336453;
    localparam word_t PcgMulB = 32'd277803737;
    localparam int    PcgSelShift = 28;
    localparam int    PcgSelBias  = 4;
    localparam int    PcgOutShift = 22;

    localparam word_t RangeLowReset  = 32'h0000_0000;
    localparam word_t RangeHighReset = 32'hFFFF_FFFF;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_A,
        ST_ADD,
        ST_XS,
        ST_MUL_B,
        ST_FOLD,
        ST_SPAN,
        ST_REM,
        ST_OUT
    } state_t;

    // remainder unit handshake
    typedef struct packed {
        logic busy;
        logic done;
    } rem_status_t;

endpackage

// File: sv/pcgh_mul.sv
module pcgh_mul (
    input  logic           aclk,
    input  pcgh_pkg::word_t a,
    input  pcgh_pkg::word_t b,
    output pcgh_pkg::word_t prod
);
    import pcgh_pkg::*;

    word_t prod_reg;
    word_t prod_next;

    // low word of the product only: wrapping multiply
    always_comb begin
        prod_next = word_t'(a * b);
    end

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

// File: sv/pcgh_rem.sv
`include "pcg_hash_range_generator_defines.svh"

module pcgh_rem (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  pcgh_pkg::word_t       dividend,
    input  pcgh_pkg::word_t       divisor,
    output pcgh_pkg::rem_status_t status,
    output pcgh_pkg::word_t       remainder
);
    import pcgh_pkg::*;

    localparam int CntWidth = $clog2(WordWidth);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CntWidth-1:0] cnt_reg, cnt_next;
    word_t               dvd_reg, dvd_next;
    word_t               div_reg, div_next;
    word_t               rem_reg, rem_next;
    logic [WordWidth:0]  trial;
    logic [WordWidth:0]  diff;

    // restoring remainder, one dividend bit a cycle
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;
        trial     = {rem_reg, dvd_reg[WordWidth-1]};
        diff      = trial - {1'b0, div_reg};
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = dividend;
            div_next  = divisor;
            rem_next  = '0;
        end else if (busy_reg) begin
            dvd_next = {dvd_reg[WordWidth-2:0], 1'b0};
            if (!diff[WordWidth]) begin
                rem_next = diff[WordWidth-1:0];
            end else begin
                rem_next = trial[WordWidth-1:0];
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CntWidth'(WordWidth - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        dvd_reg <= dvd_next;
        div_reg <= div_next;
        rem_reg <= rem_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign remainder   = rem_reg;

    `PCGH_ASSERT_NEXT(a_start_busy, start, busy_reg && cnt_reg == '0, "rem: start did not arm")
    `PCGH_ASSERT_NOW(a_rem_below, done_reg, rem_reg < div_reg, "rem: remainder not below divisor")
    `PCGH_ASSERT_NOW(a_done_idle, done_reg, !busy_reg, "rem: done while still busy")

endmodule

// File: sv/pcg_hash_range_generator.sv
// Load word: no result; loads can be taken one per cycle while idle. Draw word: two passes
// through the shared multiplier and the 32-step remainder unit before m_valid; the
// full-range case skips the remainder. A new word is taken only in idle, so draws do
// not overlap; s_ready is low while a draw is in flight or a result is blocked. aresetn
// (synchronous, active low) clears the seed and range_low, sets range_high to all ones,
// empties the output.
`include "pcg_hash_range_generator_defines.svh"

module pcg_hash_range_generator (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_mode,
    input  pcgh_pkg::word_t      s_seed_value,
    output logic                 m_valid,
    input  logic                 m_ready,
    output pcgh_pkg::word_t      m_value,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  pcgh_pkg::cfg_idx_t   cfg_index,
    input  pcgh_pkg::word_t      cfg_value
);
    import pcgh_pkg::*;

    state_t      state_reg, state_next;
    word_t       seed_reg, seed_next;
    word_t       low_reg, low_next;
    word_t       high_reg, high_next;
    word_t       work_reg, work_next;
    word_t       span_reg, span_next;
    logic        m_valid_reg, m_valid_next;
    word_t       m_value_reg, m_value_next;

    word_t       mul_a, mul_b, prod;
    logic        rem_start;
    rem_status_t rem_stat;
    word_t       rem_val;
    logic [4:0]  xs_amt;
    word_t       fold;
    logic        in_acc;

    pcgh_mul u_mul (
        .aclk (aclk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    pcgh_rem u_rem (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (rem_start),
        .dividend  (seed_reg),
        .divisor   (span_reg),
        .status    (rem_stat),
        .remainder (rem_val)
    );

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign in_acc    = s_valid && s_ready;

    assign xs_amt = 5'(work_reg[WordWidth-1:PcgSelShift]) + 5'(PcgSelBias);
    assign fold   = (prod >> PcgOutShift) ^ prod;

    always_comb begin
        state_next   = state_reg;
        seed_next    = seed_reg;
        low_next     = low_reg;
        high_next    = high_reg;
        work_next    = work_reg;
        span_next    = span_reg;
        m_valid_next = m_valid_reg;
        m_value_next = m_value_reg;
        rem_start    = 1'b0;
        mul_a        = work_reg;
        mul_b        = PcgMulB;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        if (cfg_valid) begin
            if (cfg_index == CfgIdxLow) begin
                low_next = cfg_value;
            end else if (cfg_index == CfgIdxHigh) begin
                high_next = cfg_value;
            end
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    if (s_mode) begin
                        seed_next = s_seed_value;
                    end else begin
                        state_next = ST_MUL_A;
                    end
                end
            end
            ST_MUL_A: begin
                mul_a      = seed_reg;
                mul_b      = PcgMulA;
                state_next = ST_ADD;
            end
            ST_ADD: begin
                work_next  = prod + PcgAddA;
                state_next = ST_XS;
            end
            ST_XS: begin
                work_next  = (work_reg >> xs_amt) ^ work_reg;
                state_next = ST_MUL_B;
            end
            ST_MUL_B: begin
                state_next = ST_FOLD;
            end
            ST_FOLD: begin
                seed_next  = fold;
                span_next  = high_reg - low_reg + 1'b1;
                state_next = ST_SPAN;
            end
            ST_SPAN: begin
                // span wrapped to zero: full range, raw hash
                if (span_reg == '0) begin
                    work_next  = seed_reg;
                    state_next = ST_OUT;
                end else begin
                    rem_start  = 1'b1;
                    state_next = ST_REM;
                end
            end
            ST_REM: begin
                if (rem_stat.done) begin
                    work_next  = rem_val;
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_value_next = low_reg + work_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            seed_reg    <= '0;
            low_reg     <= RangeLowReset;
            high_reg    <= RangeHighReset;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            seed_reg    <= seed_next;
            low_reg     <= low_next;
            high_reg    <= high_next;
            m_valid_reg <= m_valid_next;
        end
        work_reg    <= work_next;
        span_reg    <= span_next;
        m_value_reg <= m_value_next;
    end

    assign m_valid = m_valid_reg;
    assign m_value = m_value_reg;

    `PCGH_ASSERT_NEXT(a_load_seed, in_acc && s_mode, seed_reg == $past(s_seed_value), "load word did not set seed")
    `PCGH_ASSERT_NEXT(a_draw_start, in_acc && !s_mode, state_reg == ST_MUL_A, "draw word did not start hash")
    `PCGH_ASSERT_NOW(a_rem_owner, rem_stat.busy || rem_stat.done, state_reg == ST_REM, "remainder unit active outside its state")
    `PCGH_ASSERT_NOW(a_out_free, state_reg == ST_OUT && !m_valid_reg, state_next == ST_IDLE, "result held with free output")

endmodule
